// ----- hdl/rpc_pkg.sv -----
// shared types and constants for the packet classifier
package rpc_pkg;

  localparam int MAX_PAYLOAD_DEF = 2048;
  localparam int OFS_W = 17;

  localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
  localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;

  localparam logic REG_MAX_VER = 1'b0;
  localparam logic REG_MAX_MTU = 1'b1;

  // one finished packet waiting for the back end
  typedef struct packed {
    logic [10:0]      len;
    logic             udp;
    logic [7:0]       count;
    logic [OFS_W-1:0] npos;
  } job_t;

endpackage

// ----- hdl/rpc_front.sv -----
// byte capture into a two-bank packet store
module rpc_front import rpc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  input  logic [10:0]                    payload_len,
  input  logic                           is_udp,
  input  logic [7:0]                     flow_packet_count,
  input  logic                           wr_bank,
  input  logic                           q_full,
  output logic                           push,
  output job_t                           push_job,
  input  logic                           rd_bank,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_PAYLOAD)-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam int PW = AW + 1;

  logic [7:0]    mem [2*MAX_PAYLOAD];
  logic [PW-1:0] byte_position;
  logic [PW-1:0] pos_inc;
  logic          room;
  logic          acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign room     = byte_position < PW'(MAX_PAYLOAD);
  assign pos_inc  = room ? byte_position + PW'(1) : byte_position;

  assign push              = acc && last_byte;
  assign push_job.len      = payload_len;
  assign push_job.udp      = is_udp;
  assign push_job.count    = flow_packet_count;
  assign push_job.npos     = OFS_W'(pos_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (acc) begin
      byte_position <= last_byte ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && room) begin
      mem[{wr_bank, byte_position[AW-1:0]}] <= data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[{rd_bank, rd_addr}];
    end
  end

endmodule

// ----- hdl/rpc_jobq.sv -----
// two-entry queue of finished packets, one store bank per entry
module rpc_jobq import rpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output logic wr_ptr,
  output logic rd_ptr,
  output job_t head
);

  job_t       q [2];
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign nonempty = fill != 2'd0;
  assign head     = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_job;
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("job queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (fill == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with split pointers");

endmodule

// ----- hdl/rpc_back.sv -----
// packet judgement sequencer reading the packet store
module rpc_back import rpc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  job_t                           job,
  output logic                           pop,
  output logic                           rd_en,
  output logic [$clog2(MAX_PAYLOAD)-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  input  logic [7:0]                     max_protocol_version,
  input  logic [15:0]                    max_mtu,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     verdict
);

  localparam int AW = $clog2(MAX_PAYLOAD);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_OP   = 4'd1;
  localparam logic [3:0] P_VER  = 4'd2;
  localparam logic [3:0] P_MTUS = 4'd3;
  localparam logic [3:0] P_IP   = 4'd4;
  localparam logic [3:0] P_WHI  = 4'd5;
  localparam logic [3:0] P_WLO  = 4'd6;
  localparam logic [3:0] P_ADR  = 4'd7;
  localparam logic [3:0] P_ACK  = 4'd8;
  localparam logic [3:0] P_FSF  = 4'd9;

  localparam logic [1:0] W_MTU   = 2'd0;
  localparam logic [1:0] W_MOTD  = 2'd1;
  localparam logic [1:0] W_TOTAL = 2'd2;
  localparam logic [1:0] W_SIZE  = 2'd3;

  logic [3:0]       phase, phase_next;
  logic [1:0]       purpose, purpose_next;
  logic [3:0]       need, need_next;
  logic [7:0]       field_hi, field_hi_next;
  logic [OFS_W-1:0] pos, pos_next;
  logic [15:0]      record_total, record_total_next;
  logic [15:0]      record_done, record_done_next;
  logic [7:0]       flags, flags_next;
  logic [3:0]       iter, iter_next;
  logic [OFS_W-1:0] last_addr;
  logic             rok;

  logic             issue;
  logic [OFS_W-1:0] iaddr;
  logic             fin;
  logic [1:0]       fin_v;
  logic [7:0]       byte_v;
  logic [15:0]      word;
  logic [OFS_W-1:0] len17;
  logic [OFS_W-1:0] step;
  logic [OFS_W-1:0] span;
  logic [15:0]      done_inc;
  logic [2:0]       rel;
  logic             start;

  assign byte_v  = rok ? rd_data : 8'd0;
  assign word    = {field_hi, byte_v};
  assign len17   = OFS_W'(job.len);
  assign rd_en   = issue;
  assign rd_addr = iaddr[AW-1:0];
  assign pop     = fin;
  assign start   = (phase == P_IDLE) && job_valid && (!out_valid || out_ready);
  assign rel     = flags[7:5];

  function automatic logic [1:0] by_count(input logic [7:0] cnt, input logic [3:0] thr);
    by_count = (cnt < {4'd0, thr}) ? VERDICT_UNDECIDED : VERDICT_DETECTED;
  endfunction

  always_comb begin
    phase_next        = phase;
    purpose_next      = purpose;
    need_next         = need;
    field_hi_next     = field_hi;
    pos_next          = pos;
    record_total_next = record_total;
    record_done_next  = record_done;
    flags_next        = flags;
    iter_next         = iter;
    issue             = 1'b0;
    iaddr             = '0;
    fin               = 1'b0;
    fin_v             = VERDICT_EXCLUDED;
    step              = '0;
    span              = '0;
    done_inc          = record_done + 16'd1;
    case (phase)
      P_IDLE: begin
        if (start) begin
          if (!job.udp || job.len < 11'd7) begin
            fin = 1'b1;
          end else begin
            issue      = 1'b1;
            phase_next = P_OP;
          end
        end
      end
      P_OP: begin
        case (byte_v)
          8'h00: begin
            fin = 1'b1;
            if (job.len == 11'd8) fin_v = by_count(job.count, 4'd6);
          end
          8'h01, 8'h02: begin
            fin = 1'b1;
            if (job.len == 11'd32) fin_v = by_count(job.count, 4'd6);
          end
          8'h03, 8'h09: begin
            fin = 1'b1;
            if (job.len == 11'd16) fin_v = by_count(job.count, 4'd6);
          end
          8'h05, 8'h19: begin
            if ((byte_v == 8'h05) ? (job.len < 11'd18) : (job.len != 11'd25)) begin
              fin = 1'b1;
            end else begin
              need_next  = (byte_v == 8'h05) ? 4'd6 : 4'd3;
              issue      = 1'b1;
              iaddr      = OFS_W'(17);
              phase_next = P_VER;
            end
          end
          8'h06: begin
            if (job.len != 11'd28) begin
              fin = 1'b1;
            end else begin
              need_next  = 4'd4;
              issue      = 1'b1;
              iaddr      = OFS_W'(25);
              phase_next = P_MTUS;
            end
          end
          8'h07, 8'h08: begin
            if ((byte_v == 8'h07) ? (job.len != 11'd34) : (job.len != 11'd35)) begin
              fin = 1'b1;
            end else begin
              need_next  = 4'd3;
              pos_next   = (byte_v == 8'h07) ? OFS_W'(20) : OFS_W'(28);
              issue      = 1'b1;
              iaddr      = (byte_v == 8'h07) ? OFS_W'(17) : OFS_W'(25);
              phase_next = P_IP;
            end
          end
          8'h10, 8'h13: begin
            // first address sits on the opcode, so it never adds a span
            pos_next   = (byte_v == 8'h10) ? OFS_W'(6) : OFS_W'(4);
            iter_next  = '0;
            issue      = 1'b1;
            iaddr      = (byte_v == 8'h10) ? OFS_W'(6) : OFS_W'(4);
            phase_next = P_ADR;
          end
          8'h15, 8'hfe: begin
            fin   = 1'b1;
            fin_v = by_count(job.count, 4'd8);
          end
          8'h1c: begin
            if (job.len < 11'd35) begin
              fin = 1'b1;
            end else begin
              purpose_next = W_MOTD;
              issue        = 1'b1;
              iaddr        = OFS_W'(33);
              phase_next   = P_WHI;
            end
          end
          8'ha0, 8'hc0: begin
            purpose_next = W_TOTAL;
            issue        = 1'b1;
            iaddr        = OFS_W'(1);
            phase_next   = P_WHI;
          end
          default: begin
            if (byte_v >= 8'h80 && byte_v <= 8'h8d) begin
              pos_next   = OFS_W'(4);
              issue      = 1'b1;
              iaddr      = OFS_W'(4);
              phase_next = P_FSF;
            end else begin
              fin = 1'b1;
            end
          end
        endcase
      end
      P_VER: begin
        fin = 1'b1;
        if (byte_v <= max_protocol_version) fin_v = by_count(job.count, need);
      end
      P_MTUS: begin
        if (byte_v > 8'd1) begin
          fin = 1'b1;
        end else begin
          purpose_next = W_MTU;
          issue        = 1'b1;
          iaddr        = OFS_W'(26);
          phase_next   = P_WHI;
        end
      end
      P_IP: begin
        if (byte_v == 8'h04 || byte_v == 8'h06) begin
          purpose_next = W_MTU;
          issue        = 1'b1;
          iaddr        = pos + ((byte_v == 8'h04) ? OFS_W'(4) : OFS_W'(16));
          phase_next   = P_WHI;
        end else begin
          fin = 1'b1;
        end
      end
      P_WHI: begin
        field_hi_next = byte_v;
        issue         = 1'b1;
        iaddr         = last_addr + OFS_W'(1);
        phase_next    = P_WLO;
      end
      P_WLO: begin
        case (purpose)
          W_MTU: begin
            fin = 1'b1;
            if (word <= max_mtu) fin_v = by_count(job.count, need);
          end
          W_MOTD: begin
            fin = 1'b1;
            if (word != 16'd0 && OFS_W'(word) + OFS_W'(35) == len17)
              fin_v = by_count(job.count, 4'd3);
          end
          W_TOTAL: begin
            record_total_next = word;
            record_done_next  = '0;
            pos_next          = OFS_W'(3);
            issue             = 1'b1;
            iaddr             = OFS_W'(3);
            phase_next        = P_ACK;
          end
          default: begin
            // frame header: size in bits, reliability-dependent extras
            if (word[15:3] == 13'd0) begin
              fin = 1'b1;
            end else begin
              if (rel >= 3'd2 && rel <= 3'd4) step = step + OFS_W'(3);
              if (rel == 3'd1 || rel == 3'd4) step = step + OFS_W'(3);
              if (rel == 3'd3 || rel == 3'd7) step = step + OFS_W'(4);
              if (flags[4]) step = step + OFS_W'(10);
              step = pos + step + OFS_W'(word[15:3]) + OFS_W'(3);
              if (step + OFS_W'(3) <= len17) begin
                pos_next   = step;
                issue      = 1'b1;
                iaddr      = step;
                phase_next = P_FSF;
              end else begin
                fin = 1'b1;
                if (step == len17) fin_v = VERDICT_DETECTED;
              end
            end
          end
        endcase
      end
      P_ADR: begin
        if (pos + OFS_W'(1) < len17) begin
          if (byte_v == 8'h04) span = OFS_W'(4);
          else if (byte_v == 8'h06) span = OFS_W'(16);
        end
        step      = pos + OFS_W'(3) + span;
        iter_next = iter + 4'd1;
        pos_next  = step;
        if (iter == 4'd9) begin
          fin = 1'b1;
          if (step + OFS_W'(16) == len17) fin_v = by_count(job.count, 4'd3);
        end else begin
          issue = 1'b1;
          iaddr = step;
        end
      end
      P_ACK: begin
        if (byte_v == 8'h00 || byte_v == 8'h01) begin
          step             = pos + ((byte_v == 8'h00) ? OFS_W'(7) : OFS_W'(4));
          pos_next         = step;
          record_done_next = done_inc;
          if (done_inc < record_total && step + OFS_W'(4) <= len17) begin
            issue = 1'b1;
            iaddr = step;
          end else begin
            fin = 1'b1;
            if (done_inc == record_total && step == len17) fin_v = VERDICT_DETECTED;
          end
        end else begin
          fin = 1'b1;
        end
      end
      P_FSF: begin
        flags_next = byte_v;
        if (byte_v[3:0] != 4'd0) begin
          fin = 1'b1;
        end else begin
          purpose_next = W_SIZE;
          issue        = 1'b1;
          iaddr        = pos + OFS_W'(1);
          phase_next   = P_WHI;
        end
      end
      default: begin
        phase_next = P_IDLE;
      end
    endcase
    if (fin) phase_next = P_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (fin)            out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    purpose      <= purpose_next;
    need         <= need_next;
    field_hi     <= field_hi_next;
    pos          <= pos_next;
    record_total <= record_total_next;
    record_done  <= record_done_next;
    flags        <= flags_next;
    iter         <= iter_next;
    if (fin) verdict <= fin_v;
    if (issue) begin
      last_addr <= iaddr;
      rok       <= (iaddr < job.npos) && (iaddr < len17);
    end
  end

  assert property (@(posedge clk) disable iff (rst) (phase != P_IDLE) |-> job_valid)
    else $error("sequencer busy without a queued packet");
  assert property (@(posedge clk) disable iff (rst) fin |-> (!out_valid || out_ready))
    else $error("verdict produced over an untaken one");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (verdict != 2'd3))
    else $error("illegal verdict code");

endmodule

// ----- hdl/raknet_packet_classifier_top.sv -----
// packet classifier top level: config registers, capture, queue and judgement
// throughput: one byte per cycle; input stalls only while both store banks hold packets
//   awaiting judgement or an untaken verdict
// reset: synchronous, clears byte count, queue and sequencer; limits return to 10 and 1500
module raknet_packet_classifier_top import rpc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte[7:0], payload_len[18:8], flow_packet_count[26:19]
  input  logic        s_axis_tlast,  // last_byte
  input  logic        s_axis_tuser,  // is_udp
  // verdict out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // verdict[1:0]
);

  localparam int AW = $clog2(MAX_PAYLOAD);

  logic [7:0]    max_protocol_version;
  logic [15:0]   max_mtu;
  logic          cfg_wr;

  logic          push, pop, q_full, q_nonempty, wr_ptr, rd_ptr;
  job_t          push_job, head;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [1:0]    verdict;

  // configuration registers, paddr bit 2 picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_MTU) ? {16'd0, max_mtu} : {24'd0, max_protocol_version};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_protocol_version <= 8'd10;
      max_mtu              <= 16'd1500;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_VER) max_protocol_version <= pwdata[7:0];
      else                         max_mtu              <= pwdata[15:0];
    end
  end

  // front: stores each byte that fits the store, hands a packet over on its last transfer
  rpc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .data_byte         (s_axis_tdata[7:0]),
    .last_byte         (s_axis_tlast),
    .payload_len       (s_axis_tdata[18:8]),
    .is_udp            (s_axis_tuser),
    .flow_packet_count (s_axis_tdata[26:19]),
    .wr_bank           (wr_ptr),
    .q_full            (q_full),
    .push              (push),
    .push_job          (push_job),
    .rd_bank           (rd_ptr),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data)
  );

  // queue of whole packets between front and back
  rpc_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .wr_ptr   (wr_ptr),
    .rd_ptr   (rd_ptr),
    .head     (head)
  );

  // back: walks the stored packet and registers the verdict
  rpc_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .job_valid            (q_nonempty),
    .job                  (head),
    .pop                  (pop),
    .rd_en                (rd_en),
    .rd_addr              (rd_addr),
    .rd_data              (rd_data),
    .max_protocol_version (max_protocol_version),
    .max_mtu              (max_mtu),
    .out_valid            (m_axis_tvalid),
    .out_ready            (m_axis_tready),
    .verdict              (verdict)
  );

  assign m_axis_tdata = {6'd0, verdict};

endmodule

// ----- dv/raknet_packet_classifier_top_tb.sv -----
// testbench for the raknet packet classifier: byte stream in, verdicts checked against a predictor
module raknet_packet_classifier_top_tb;
  import rpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // a small store keeps the overflow case short
  localparam int MAX_BYTES   = 256;
  localparam int CYCLE_LIMIT = 1000000;

  // opcodes walked by the classifier, and one unknown opcode
  localparam logic [7:0] OP_PING        = 8'h00;
  localparam logic [7:0] OP_PING_OPEN   = 8'h01;
  localparam logic [7:0] OP_PING_ALT    = 8'h02;
  localparam logic [7:0] OP_PONG_CONN   = 8'h03;
  localparam logic [7:0] OP_OPEN_REQ1   = 8'h05;
  localparam logic [7:0] OP_OPEN_REP1   = 8'h06;
  localparam logic [7:0] OP_OPEN_REQ2   = 8'h07;
  localparam logic [7:0] OP_OPEN_REP2   = 8'h08;
  localparam logic [7:0] OP_CONN_REQ    = 8'h09;
  localparam logic [7:0] OP_CONN_ACCEPT = 8'h10;
  localparam logic [7:0] OP_NEW_INCOM   = 8'h13;
  localparam logic [7:0] OP_DISCONNECT  = 8'h15;
  localparam logic [7:0] OP_INCOMPAT    = 8'h19;
  localparam logic [7:0] OP_UNCONN_PONG = 8'h1c;
  localparam logic [7:0] OP_NACK        = 8'ha0;
  localparam logic [7:0] OP_ACK         = 8'hc0;
  localparam logic [7:0] OP_GAME        = 8'hfe;
  localparam logic [7:0] OP_FRAME_LO    = 8'h80;
  localparam logic [7:0] OP_FRAME_MID   = 8'h84;
  localparam logic [7:0] OP_FRAME_HI    = 8'h8d;
  localparam logic [7:0] OP_UNKNOWN     = 8'h42;

  localparam logic [7:0] IP_V4        = 8'h04;
  localparam logic [7:0] IP_V6        = 8'h06;
  localparam logic [7:0] REC_RANGE    = 8'h00;
  localparam logic [7:0] REC_SINGLE   = 8'h01;
  localparam logic [7:0] FLAG_SPLIT   = 8'h10;
  localparam logic [7:0] FLAG_RESVD   = 8'h0f;
  localparam logic [7:0] FLAG_REL     = 8'he0;

  localparam logic [7:0] OP_LIST [20] = '{OP_PING, OP_PING_OPEN, OP_PING_ALT, OP_PONG_CONN,
    OP_OPEN_REQ1, OP_OPEN_REP1, OP_OPEN_REQ2, OP_OPEN_REP2, OP_CONN_REQ, OP_CONN_ACCEPT,
    OP_NEW_INCOM, OP_DISCONNECT, OP_INCOMPAT, OP_UNCONN_PONG, OP_NACK, OP_ACK, OP_GAME,
    OP_FRAME_LO, OP_FRAME_MID, OP_FRAME_HI};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // data_byte[7:0], payload_len[18:8], flow_packet_count[26:19]
  logic        s_axis_tlast = 1'b0;  // last_byte
  logic        s_axis_tuser = 1'b0;  // is_udp
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // verdict[1:0]

  raknet_packet_classifier_top #(.MAX_PAYLOAD(MAX_BYTES)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: register copies, byte capture and the verdicts still owed
  logic [7:0]  ver_limit = 8'd10;
  logic [15:0] mtu_limit = 16'd1500;
  logic [7:0]  pkt_mem [MAX_BYTES];
  int unsigned byte_pos = 0;
  int unsigned pkt_len = 0;
  logic [1:0]  verdict_q [$];
  int          fail_count = 0;
  int          cycles = 0;
  bit          quiet = 0;   // no idling on either side while set
  int          bytes_sent = 0;

  // ---------------------------------------------------------------- predictor

  // a byte not yet received, past the payload length or past the store reads as zero
  function automatic int unsigned pick(int unsigned i);
    if (i >= byte_pos || i >= pkt_len || i >= MAX_BYTES) return 0;
    return pkt_mem[i];
  endfunction

  function automatic int unsigned pick16(int unsigned i);
    return (pick(i) << 8) | pick(i + 1);
  endfunction

  // length of an address body given its ip-type byte
  function automatic int unsigned addr_span(int unsigned at);
    int unsigned b;
    if (at + 1 >= pkt_len) return 0;
    b = pick(at);
    if (b == IP_V4) return 4;
    if (b == IP_V6) return 16;
    return 0;
  endfunction

  function automatic logic [1:0] classify(bit udp, int unsigned cnt);
    int unsigned op, ip, off, total, done, pos, kind, fo, flags, size, rel;
    int unsigned need;
    need = 3;
    if (!udp || pkt_len < 7) return VERDICT_EXCLUDED;
    op = pick(0);
    case (op)
      OP_PING: begin
        if (pkt_len != 8) return VERDICT_EXCLUDED;
        need = 6;
      end
      OP_PING_OPEN, OP_PING_ALT: begin
        if (pkt_len != 32) return VERDICT_EXCLUDED;
        need = 6;
      end
      OP_PONG_CONN, OP_CONN_REQ: begin
        if (pkt_len != 16) return VERDICT_EXCLUDED;
        need = 6;
      end
      OP_OPEN_REQ1: begin
        if (pkt_len < 18 || pick(17) > ver_limit) return VERDICT_EXCLUDED;
        need = 6;
      end
      OP_OPEN_REP1: begin
        if (pkt_len != 28 || pick(25) > 1) return VERDICT_EXCLUDED;
        if (pick16(26) > mtu_limit) return VERDICT_EXCLUDED;
        need = 4;
      end
      OP_OPEN_REQ2: begin
        ip = addr_span(17);
        if (pkt_len != 34 || ip == 0) return VERDICT_EXCLUDED;
        if (pick16(20 + ip) > mtu_limit) return VERDICT_EXCLUDED;
      end
      OP_OPEN_REP2: begin
        ip = addr_span(25);
        if (pkt_len != 35 || ip == 0) return VERDICT_EXCLUDED;
        if (pick16(28 + ip) > mtu_limit) return VERDICT_EXCLUDED;
      end
      OP_CONN_ACCEPT, OP_NEW_INCOM: begin
        // the first address is looked up at offset zero, so it never adds a body
        off = 4 + addr_span(0);
        if (op == OP_CONN_ACCEPT) off += 2;
        for (int i = 0; i < 10; i++) off += 3 + addr_span(off);
        off += 16;
        if (off != pkt_len) return VERDICT_EXCLUDED;
      end
      OP_DISCONNECT, OP_GAME: need = 8;
      OP_INCOMPAT: begin
        if (pkt_len != 25 || pick(17) > ver_limit) return VERDICT_EXCLUDED;
      end
      OP_UNCONN_PONG: begin
        if (pkt_len < 35) return VERDICT_EXCLUDED;
        total = pick16(33);
        if (total == 0 || total + 35 != pkt_len) return VERDICT_EXCLUDED;
      end
      OP_NACK, OP_ACK: begin
        // ack/nack verdict ignores the packet count
        total = pick16(1);
        done = 0;
        pos = 3;
        do begin
          kind = pick(pos);
          if (kind == REC_RANGE) pos += 7;
          else if (kind == REC_SINGLE) pos += 4;
          else return VERDICT_EXCLUDED;
          done++;
        end while (done < total && pos + 4 <= pkt_len);
        return (done == total && pos == pkt_len) ? VERDICT_DETECTED : VERDICT_EXCLUDED;
      end
      default: begin
        if (op < OP_FRAME_LO || op > OP_FRAME_HI) return VERDICT_EXCLUDED;
        // frame set: walk each frame header, zero-size message rejects
        fo = 4;
        do begin
          flags = pick(fo);
          if ((flags & FLAG_RESVD) != 0) return VERDICT_EXCLUDED;
          size = pick16(fo + 1) / 8;
          if (size == 0) return VERDICT_EXCLUDED;
          rel = (flags & FLAG_REL) >> 5;
          if (rel >= 2 && rel <= 4) fo += 3;
          if (rel == 1 || rel == 4) fo += 3;
          if (rel == 3 || rel == 7) fo += 4;
          if ((flags & FLAG_SPLIT) != 0) fo += 10;
          fo += size + 3;
        end while (fo + 3 <= pkt_len);
        return (fo == pkt_len) ? VERDICT_DETECTED : VERDICT_EXCLUDED;
      end
    endcase
    return (cnt < need) ? VERDICT_UNDECIDED : VERDICT_DETECTED;
  endfunction

  // ---------------------------------------------------------------- idling

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: runs of ready with occasional stalls of random length
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) < 3) stall_left <= gap_len();
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("verdict transfer with none owed: got %0d", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== {6'd0, verdict_q[0]}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("verdict mismatch: expected %0d got %0d", verdict_q[0], m_axis_tdata);
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // generous cycle limit; a hang ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // apb write: setup cycle then access cycle, predictor copy updated alongside
  task automatic reg_write(logic regsel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_MAX_VER) ver_limit = value[7:0];
    else mtu_limit = value[15:0];
  endtask

  // one byte transfer; the predictor sees it once accepted
  task automatic send_byte(logic [7:0] data, bit last, logic [10:0] plen, bit udp,
                           logic [7:0] cnt);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, cnt, plen, data};
    s_axis_tlast <= last;
    s_axis_tuser <= udp;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (byte_pos < MAX_BYTES) begin
      pkt_mem[byte_pos] = data;
      byte_pos++;
    end
    if (last) begin
      pkt_len = plen;
      verdict_q.push_back(classify(udp, cnt));
      byte_pos = 0;
    end
  endtask

  task automatic send_packet(logic [7:0] pkt [$], int plen, bit udp, int cnt, int nsend);
    logic [7:0] b;
    for (int i = 0; i < nsend; i++) begin
      b = (i < pkt.size()) ? pkt[i] : 8'($urandom);
      send_byte(b, i == nsend - 1, 11'(plen), udp, 8'(cnt));
    end
  endtask

  // waits until every verdict has come back, then lets the back end settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- packet builder

  function automatic logic [7:0] pick_version();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, ver_limit));
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_mtu();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return mtu_limit + 16'd1;
      default: return 16'($urandom_range(0, mtu_limit));
    endcase
  endfunction

  function automatic logic [7:0] pick_ip();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return IP_V4;
    if (r < 9) return IP_V6;
    return 8'($urandom);
  endfunction

  // well-formed packet of the given opcode with random content
  task automatic build_packet(logic [7:0] op, output logic [7:0] pkt [$], output int plen);
    int n, off, cnt, fo, rel, size;
    logic [7:0] b;
    logic [15:0] w;
    pkt = {};
    case (op)
      OP_PING: plen = 8;
      OP_PING_OPEN, OP_PING_ALT: plen = 32;
      OP_PONG_CONN, OP_CONN_REQ: plen = 16;
      OP_OPEN_REQ1: plen = $urandom_range(18, 60);
      OP_OPEN_REP1: plen = 28;
      OP_OPEN_REQ2: plen = 34;
      OP_OPEN_REP2: plen = 35;
      OP_INCOMPAT: plen = 25;
      OP_DISCONNECT, OP_GAME: plen = $urandom_range(7, 40);
      OP_UNCONN_PONG: plen = 35 + $urandom_range(1, 40);
      default: plen = 1;
    endcase
    while (pkt.size() < plen) pkt.push_back(8'($urandom));
    pkt[0] = op;
    case (op)
      OP_OPEN_REQ1, OP_INCOMPAT: pkt[17] = pick_version();
      OP_OPEN_REP1: begin
        pkt[25] = 8'($urandom_range(0, 2));
        w = pick_mtu();
        pkt[26] = w[15:8];
        pkt[27] = w[7:0];
      end
      OP_OPEN_REQ2, OP_OPEN_REP2: begin
        off = (op == OP_OPEN_REQ2) ? 17 : 25;
        pkt[off] = pick_ip();
        off = ((op == OP_OPEN_REQ2) ? 20 : 28) + ((pkt[off] == IP_V6) ? 16 : 4);
        w = pick_mtu();
        if (off < plen) pkt[off] = w[15:8];
        if (off + 1 < plen) pkt[off + 1] = w[7:0];
      end
      OP_UNCONN_PONG: begin
        w = 16'(plen - 35);
        pkt[33] = w[15:8];
        pkt[34] = w[7:0];
      end
      OP_CONN_ACCEPT, OP_NEW_INCOM: begin
        off = (op == OP_CONN_ACCEPT) ? 6 : 4;
        for (int i = 0; i < 10; i++) begin
          b = ($urandom_range(0, 1)) ? IP_V4 : IP_V6;
          while (pkt.size() < off + 1) pkt.push_back(8'($urandom));
          pkt[off] = b;
          off += 3 + ((b == IP_V6) ? 16 : 4);
        end
        plen = off + 16;
        while (pkt.size() < plen) pkt.push_back(8'($urandom));
      end
      OP_NACK, OP_ACK: begin
        cnt = $urandom_range(1, 5);
        pkt[0] = op;
        pkt.push_back(8'(cnt >> 8));
        pkt.push_back(8'(cnt));
        for (int i = 0; i < cnt; i++) begin
          b = ($urandom_range(0, 1)) ? REC_RANGE : REC_SINGLE;
          pkt.push_back(b);
          n = (b == REC_RANGE) ? 6 : 3;
          repeat (n) pkt.push_back(8'($urandom));
        end
        plen = pkt.size();
      end
      default: begin
        if (op >= OP_FRAME_LO && op <= OP_FRAME_HI) begin
          repeat (3) pkt.push_back(8'($urandom));
          fo = 4;
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) begin
            rel = $urandom_range(0, 7);
            b = 8'(rel << 5);
            if ($urandom_range(0, 5) == 0) b |= FLAG_SPLIT;
            size = $urandom_range(1, 20);
            w = 16'(size * 8 + $urandom_range(0, 7));
            pkt.push_back(b);
            pkt.push_back(w[15:8]);
            pkt.push_back(w[7:0]);
            if (rel >= 2 && rel <= 4) fo += 3;
            if (rel == 1 || rel == 4) fo += 3;
            if (rel == 3 || rel == 7) fo += 4;
            if (b & FLAG_SPLIT) fo += 10;
            fo += size + 3;
            while (pkt.size() < fo) pkt.push_back(8'($urandom));
          end
          plen = fo;
        end
      end
    endcase
  endtask

  // random packet: mostly well formed, some broken, some noise
  task automatic random_packet();
    logic [7:0] pkt [$];
    int plen, nsend, cnt, r, i;
    bit udp;
    r = $urandom_range(0, 99);
    build_packet(OP_LIST[$urandom_range(0, 19)], pkt, plen);
    udp = 1;
    if (r < 6) begin
      plen = $urandom_range(0, 6);
    end else if (r < 10) begin
      udp = 0;
    end else if (r < 15) begin
      pkt[0] = 8'($urandom);
    end else if (r < 35) begin
      // corrupt one byte or nudge the length
      if ($urandom_range(0, 1)) begin
        i = $urandom_range(0, plen - 1);
        pkt[i] = 8'($urandom);
      end else begin
        plen = plen + $urandom_range(0, 1) * 2 - 1;
      end
    end
    cnt = ($urandom_range(0, 1)) ? $urandom_range(0, 10) : $urandom_range(0, 255);
    nsend = (plen == 0) ? 1 : plen;
    if ($urandom_range(0, 9) == 0) nsend = $urandom_range(1, plen + 4);
    send_packet(pkt, plen, udp, cnt, nsend);
  endtask

  // ---------------------------------------------------------------- tests

  // every opcode once well formed, then each named corner case
  task automatic test_directed();
    logic [7:0] pkt [$];
    int plen;
    foreach (OP_LIST[k]) begin
      build_packet(OP_LIST[k], pkt, plen);
      send_packet(pkt, plen, 1, (k % 2) ? 255 : 0, plen);
    end
    // too short, and not udp
    build_packet(OP_GAME, pkt, plen);
    send_packet(pkt, 6, 1, 255, 6);
    send_packet(pkt, plen, 0, 255, plen);
    // zero payload length, a single byte still closes the packet
    send_packet(pkt, 0, 1, 255, 1);
    // frame set whose message size rounds down to zero
    build_packet(OP_FRAME_MID, pkt, plen);
    pkt[5] = 8'd0;
    pkt[6] = 8'd7;
    send_packet(pkt, plen, 1, 255, plen);
    // ack with no records
    build_packet(OP_ACK, pkt, plen);
    pkt[1] = 8'd0;
    pkt[2] = 8'd0;
    send_packet(pkt, plen, 1, 255, plen);
    // unknown opcode
    build_packet(OP_GAME, pkt, plen);
    pkt[0] = OP_UNKNOWN;
    send_packet(pkt, plen, 1, 255, plen);
    // largest payload length, and more bytes than the store holds
    build_packet(OP_GAME, pkt, plen);
    send_packet(pkt, 2047, 1, 7, 48);
    send_packet(pkt, 2047, 1, 8, MAX_BYTES + 4);
    drain();
  endtask

  task automatic test_random(int nbytes);
    int stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) random_packet();
    drain();
  endtask

  // register extremes, then random values, each followed by a random phase
  task automatic test_limits();
    reg_write(REG_MAX_VER, 32'd0);
    reg_write(REG_MAX_MTU, 32'd0);
    test_random(100);
    reg_write(REG_MAX_VER, 32'd255);
    reg_write(REG_MAX_MTU, 32'd65535);
    test_random(100);
    reg_write(REG_MAX_VER, 32'($urandom_range(1, 254)));
    reg_write(REG_MAX_MTU, 32'($urandom_range(1, 65534)));
    test_random(100);
  endtask

  // back to back with no idling on either side
  task automatic test_quiet();
    reg_write(REG_MAX_VER, 32'd10);
    reg_write(REG_MAX_MTU, 32'd1500);
    quiet = 1;
    test_random(150);
    quiet = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_limits();
    test_quiet();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
